// ===== rtl/core/pal_pkg.sv =====
package pal_pkg;

  // sizes
  localparam int MAX_VERTICES = 256;
  localparam int FRAC_BITS    = 16;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int COORD_W      = 32;
  localparam int POS_W        = 40;
  localparam int THR_W        = 16;
  localparam int SEG_W        = 8;
  localparam int MAG_W        = COORD_W + 1;
  localparam int RAD_W        = 2 * MAG_W;
  localparam int ROOT_W       = MAG_W;
  localparam int DIVD_W       = MAG_W + FRAC_BITS;
  localparam int PROD_W       = POS_W + COORD_W;
  localparam int PT_W         = PROD_W - FRAC_BITS + 2;

  // opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_PAST = 2'd1;
  localparam logic [1:0] ST_FEW  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic [POS_W-1:0]         route_position;
  } req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [SEG_W-1:0]         segment_index;
    logic                     at_vertex;
    logic                     at_end;
    logic [1:0]               status;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic       load_req;
    logic       clear;
    logic       wr_first;
    logic       mul_dx;
    logic       mul_dy;
    logic       sqrt_start;
    logic       div_start;
    logic       div_sel_y;
    logic       div_store;
    logic       append_wr;
    logic       srch_init;
    logic       srch_rd;
    logic       srch_cmp;
    logic       idx_rd;
    logic       rem_load;
    logic       walk_lo;
    logic       walk_hi;
    logic       walk_pt;
    logic       walk_sel_y;
    logic       flags;
    logic       set_st;
    logic [1:0] st_code;
    logic       out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] opcode;
    logic       cnt_zero;
    logic       full;
    logic       few;
    logic       sqrt_busy;
    logic       div_busy;
    logic       srch_more;
    logic       out_busy;
  } sts_t;

endpackage

// ===== rtl/core/pal_isqrt.sv =====
module pal_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pal_pkg::RAD_W-1:0]  rad_i,
  output logic                       busy_o,
  output logic [pal_pkg::ROOT_W-1:0] root_o
);
  import pal_pkg::*;

  localparam int CW = $clog2(ROOT_W + 1);
  localparam int RW = ROOT_W + 3;

  logic [CW-1:0]     cnt_q;
  logic [RAD_W-1:0]  rad_q;
  logic [RW-1:0]     rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [RW-1:0]     rem_t;
  logic [RW-1:0]     trial;
  logic              ge;

  // one root bit per step
  always_comb begin
    rem_t = {rem_q[RW-3:0], rad_q[RAD_W-1 -: 2]};
    trial = RW'({root_q, 2'b01});
    ge    = rem_t >= trial;
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(ROOT_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // remainder and root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= ge ? rem_t - trial : rem_t;
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign busy_o = cnt_q != '0;
  assign root_o = root_q;

endmodule

// ===== rtl/core/pal_div.sv =====
module pal_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pal_pkg::DIVD_W-1:0] dividend_i,
  input  logic [pal_pkg::ROOT_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic [pal_pkg::DIVD_W-1:0] quot_o
);
  import pal_pkg::*;

  localparam int CW = $clog2(DIVD_W + 1);

  logic [CW-1:0]     cnt_q;
  logic [DIVD_W-1:0] num_q;
  logic [ROOT_W-1:0] den_q;
  logic [ROOT_W-1:0] rem_q;
  logic [ROOT_W:0]   rem_t;
  logic [ROOT_W:0]   diff;
  logic              ge;

  // restoring step, one quotient bit per cycle
  always_comb begin
    rem_t = {rem_q, num_q[DIVD_W-1]};
    diff  = rem_t - {1'b0, den_q};
    ge    = rem_t >= {1'b0, den_q};
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(DIVD_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // quotient shifts into the dividend register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[DIVD_W-2:0], ge};
      rem_q <= ge ? diff[ROOT_W-1:0] : rem_t[ROOT_W-1:0];
    end
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = num_q;

endmodule

// ===== rtl/core/pal_dp.sv =====
module pal_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pal_pkg::req_t             in_req_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output pal_pkg::rsp_t             out_rsp_o,
  input  logic                      cfg_we_i,
  input  logic [pal_pkg::THR_W-1:0] cfg_wdata_i,
  input  pal_pkg::cmd_t             cmd_i,
  output pal_pkg::sts_t             sts_o
);
  import pal_pkg::*;

  localparam logic signed [PT_W-1:0] SAT_HI = PT_W'({(COORD_W-1){1'b1}});
  localparam logic signed [PT_W-1:0] SAT_LO = -SAT_HI - PT_W'(1);

  // memories
  logic [COORD_W-1:0] vx_mem   [MAX_VERTICES];
  logic [COORD_W-1:0] vy_mem   [MAX_VERTICES];
  logic [COORD_W-1:0] dirx_mem [MAX_VERTICES];
  logic [COORD_W-1:0] diry_mem [MAX_VERTICES];
  logic [POS_W-1:0]   seg_mem  [MAX_VERTICES];
  logic [POS_W-1:0]   cum_mem  [MAX_VERTICES];

  logic signed [COORD_W-1:0] vx_rd_q, vy_rd_q, dirx_rd_q, diry_rd_q;
  logic [POS_W-1:0]          seg_rd_q, cum_rd_q;

  // state
  logic [THR_W-1:0]          thr_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [POS_W-1:0]          total_q;
  logic signed [COORD_W-1:0] first_x_q, first_y_q, last_x_q, last_y_q;
  req_t                      req_q;
  rsp_t                      res_q;
  rsp_t                      out_rsp_q;
  logic                      out_valid_q;
  logic [RAD_W-1:0]          sq_q, rad_q;
  logic [COORD_W-1:0]        dirx_q, diry_q;
  logic [CNT_W-1:0]          lo_q, hi_q;
  logic [ADDR_W-1:0]         idx_q;
  logic [POS_W-1:0]          rem_q;
  logic [PROD_W-1:0]         mag_q;

  // combinational
  logic signed [MAG_W-1:0] dx, dy;
  logic [MAG_W-1:0]        dx_abs, dy_abs, mul_a, mul_b, d_abs;
  logic [RAD_W-1:0]        mul_p;
  logic                    sqrt_busy, div_busy, d_neg;
  logic [ROOT_W-1:0]       root;
  logic [DIVD_W-1:0]       quot;
  logic [COORD_W-1:0]      q_lo, dir_val;
  logic [POS_W:0]          cum_sum;
  logic [POS_W-1:0]        cum_sat;
  logic [CNT_W:0]          mid_sum;
  logic [CNT_W-1:0]        mid, lo_c;
  logic [ADDR_W-1:0]       idx, rd_addr;
  logic                    rd_en;
  logic signed [COORD_W-1:0] u, s;
  logic [COORD_W-1:0]      u_abs;
  logic signed [PT_W-1:0]  s_ext, m_ext, v;
  logic signed [COORD_W-1:0] pt;
  logic                    endp;

  // segment deltas from the previous vertex
  always_comb begin
    dx     = MAG_W'(req_q.vertex_x) - MAG_W'(last_x_q);
    dy     = MAG_W'(req_q.vertex_y) - MAG_W'(last_y_q);
    dx_abs = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    dy_abs = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
  end

  // shared multiplier
  always_comb begin
    u     = cmd_i.walk_sel_y ? diry_rd_q : dirx_rd_q;
    s     = cmd_i.walk_sel_y ? vy_rd_q : vx_rd_q;
    u_abs = u[COORD_W-1] ? COORD_W'(-u) : COORD_W'(u);
    mul_a = dx_abs;
    mul_b = dx_abs;
    if (cmd_i.mul_dy) begin
      mul_a = dy_abs;
      mul_b = dy_abs;
    end else if (cmd_i.walk_lo) begin
      mul_a = {1'b0, rem_q[COORD_W-1:0]};
      mul_b = {1'b0, u_abs};
    end else if (cmd_i.walk_hi) begin
      mul_a = MAG_W'(rem_q[POS_W-1:COORD_W]);
      mul_b = {1'b0, u_abs};
    end
    mul_p = mul_a * mul_b;
  end

  // square root and division units
  pal_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (rad_q),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  assign d_abs = cmd_i.div_sel_y ? dy_abs : dx_abs;
  assign d_neg = cmd_i.div_sel_y ? dy[MAG_W-1] : dx[MAG_W-1];

  pal_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({d_abs, {FRAC_BITS{1'b0}}}),
    .divisor_i  (root),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // direction and cumulative length
  always_comb begin
    q_lo    = quot[COORD_W-1:0];
    dir_val = (root == '0) ? '0 : (d_neg ? COORD_W'(-q_lo) : q_lo);
    cum_sum = {1'b0, total_q} + (POS_W + 1)'(root);
    cum_sat = cum_sum[POS_W] ? '1 : cum_sum[POS_W-1:0];
  end

  // search addressing
  always_comb begin
    mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
    mid     = mid_sum[CNT_W:1];
    lo_c    = (lo_q >= cnt_q) ? cnt_q - 1'b1 : lo_q;
    idx     = ADDR_W'(lo_c - 1'b1);
    rd_addr = cmd_i.idx_rd ? idx : mid[ADDR_W-1:0];
    rd_en   = cmd_i.idx_rd | cmd_i.srch_rd;
  end

  // walk along the segment, saturating
  always_comb begin
    s_ext = PT_W'(s);
    m_ext = $signed(PT_W'(mag_q >> FRAC_BITS));
    v     = u[COORD_W-1] ? s_ext - m_ext : s_ext + m_ext;
    if (v > SAT_HI) begin
      pt = SAT_HI[COORD_W-1:0];
    end else if (v < SAT_LO) begin
      pt = SAT_LO[COORD_W-1:0];
    end else begin
      pt = v[COORD_W-1:0];
    end
    endp = (idx_q == '0 || {1'b0, idx_q} == cnt_q - CNT_W'(2)) &&
           ((res_q.point_x == first_x_q && res_q.point_y == first_y_q) ||
            (res_q.point_x == last_x_q && res_q.point_y == last_y_q));
  end

  // memory writes and registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_first || cmd_i.append_wr) begin
      vx_mem[cnt_q[ADDR_W-1:0]]  <= req_q.vertex_x;
      vy_mem[cnt_q[ADDR_W-1:0]]  <= req_q.vertex_y;
      cum_mem[cnt_q[ADDR_W-1:0]] <= cmd_i.wr_first ? '0 : cum_sat;
    end
    if (cmd_i.append_wr) begin
      seg_mem[ADDR_W'(cnt_q - 1'b1)]  <= POS_W'(root);
      dirx_mem[ADDR_W'(cnt_q - 1'b1)] <= dirx_q;
      diry_mem[ADDR_W'(cnt_q - 1'b1)] <= diry_q;
    end
    if (rd_en) begin
      vx_rd_q   <= vx_mem[rd_addr];
      vy_rd_q   <= vy_mem[rd_addr];
      dirx_rd_q <= dirx_mem[rd_addr];
      diry_rd_q <= diry_mem[rd_addr];
      seg_rd_q  <= seg_mem[rd_addr];
      cum_rd_q  <= cum_mem[rd_addr];
    end
  end

  // control state: count, total, threshold, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      total_q     <= '0;
      thr_q       <= THR_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (cmd_i.clear) begin
        cnt_q   <= '0;
        total_q <= '0;
      end else if (cmd_i.wr_first) begin
        cnt_q <= CNT_W'(1);
      end else if (cmd_i.append_wr) begin
        cnt_q   <= cnt_q + 1'b1;
        total_q <= cum_sat;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_req_i;
      res_q <= '0;
    end
    if (cmd_i.wr_first) begin
      first_x_q <= req_q.vertex_x;
      first_y_q <= req_q.vertex_y;
    end
    if (cmd_i.wr_first || cmd_i.append_wr) begin
      last_x_q <= req_q.vertex_x;
      last_y_q <= req_q.vertex_y;
    end
    if (cmd_i.mul_dx) begin
      sq_q <= mul_p;
    end
    if (cmd_i.mul_dy) begin
      rad_q <= sq_q + mul_p;
    end
    if (cmd_i.div_store) begin
      if (cmd_i.div_sel_y) begin
        diry_q <= dir_val;
      end else begin
        dirx_q <= dir_val;
      end
    end
    if (cmd_i.srch_init) begin
      lo_q <= '0;
      hi_q <= cnt_q;
    end else if (cmd_i.srch_cmp) begin
      if (cum_rd_q <= req_q.route_position) begin
        lo_q <= mid + 1'b1;
      end else begin
        hi_q <= mid;
      end
    end
    if (cmd_i.idx_rd) begin
      idx_q <= idx;
    end
    if (cmd_i.rem_load) begin
      rem_q <= req_q.route_position - cum_rd_q;
    end
    if (cmd_i.walk_lo) begin
      mag_q <= PROD_W'(mul_p);
    end else if (cmd_i.walk_hi) begin
      mag_q <= mag_q + {mul_p[POS_W-1:0], {COORD_W{1'b0}}};
    end
    if (cmd_i.walk_pt) begin
      if (cmd_i.walk_sel_y) begin
        res_q.point_y <= pt;
      end else begin
        res_q.point_x <= pt;
      end
    end
    if (cmd_i.flags) begin
      res_q.segment_index <= SEG_W'(idx_q);
      res_q.at_vertex     <= (rem_q < POS_W'(thr_q)) || (rem_q > seg_rd_q);
      res_q.at_end        <= endp;
      res_q.status        <= (req_q.route_position > total_q) ? ST_PAST : ST_OK;
    end
    if (cmd_i.set_st) begin
      res_q.status <= cmd_i.st_code;
    end
    if (cmd_i.out_load) begin
      out_rsp_q <= res_q;
    end
  end

  // status to controller
  always_comb begin
    sts_o.opcode    = req_q.opcode;
    sts_o.cnt_zero  = cnt_q == '0;
    sts_o.full      = cnt_q == CNT_W'(MAX_VERTICES);
    sts_o.few       = cnt_q < CNT_W'(2);
    sts_o.sqrt_busy = sqrt_busy;
    sts_o.div_busy  = div_busy;
    sts_o.srch_more = lo_q < hi_q;
    sts_o.out_busy  = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef SYNTHESIS
  // vertex count stays within the table
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_VERTICES)) else $error("vertex count overflow");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && !out_ready_i)) else $error("result overwritten");

  // search window is open and within the table when compared
  a_srch_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.srch_cmp |-> (lo_q < hi_q && hi_q <= cnt_q)) else $error("bad search window");
`endif

endmodule

// ===== rtl/core/pal_ctrl.sv =====
module pal_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pal_pkg::sts_t sts_i,
  output pal_pkg::cmd_t cmd_o
);
  import pal_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_MUL_DX, S_MUL_DY, S_SQRT, S_SQRT_WAIT,
    S_DIVX, S_DIVX_WAIT, S_DIVY, S_DIVY_WAIT, S_APPEND,
    S_SRCH_CHK, S_SRCH_CMP, S_REM,
    S_WX0, S_WX1, S_WX2, S_WY0, S_WY1, S_WY2, S_FLAGS, S_FINISH
  } state_e;

  state_e state_q, state_d;

  // command decode and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.load_req = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FINISH;
        case (sts_i.opcode)
          OP_CLEAR: begin
            cmd_o.clear = 1'b1;
          end
          OP_APPEND: begin
            if (sts_i.full) begin
              cmd_o.set_st  = 1'b1;
              cmd_o.st_code = ST_FULL;
            end else if (sts_i.cnt_zero) begin
              cmd_o.wr_first = 1'b1;
            end else begin
              state_d = S_MUL_DX;
            end
          end
          OP_QUERY: begin
            if (sts_i.few) begin
              cmd_o.set_st  = 1'b1;
              cmd_o.st_code = ST_FEW;
            end else begin
              cmd_o.srch_init = 1'b1;
              state_d         = S_SRCH_CHK;
            end
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end
      S_MUL_DX: begin
        cmd_o.mul_dx = 1'b1;
        state_d      = S_MUL_DY;
      end
      S_MUL_DY: begin
        cmd_o.mul_dy = 1'b1;
        state_d      = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (!sts_i.sqrt_busy) begin
          state_d = S_DIVX;
        end
      end
      S_DIVX: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVX_WAIT;
      end
      S_DIVX_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.div_store = 1'b1;
          state_d         = S_DIVY;
        end
      end
      S_DIVY: begin
        cmd_o.div_sel_y = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVY_WAIT;
      end
      S_DIVY_WAIT: begin
        cmd_o.div_sel_y = 1'b1;
        if (!sts_i.div_busy) begin
          cmd_o.div_store = 1'b1;
          state_d         = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd_o.append_wr = 1'b1;
        state_d         = S_FINISH;
      end
      S_SRCH_CHK: begin
        if (sts_i.srch_more) begin
          cmd_o.srch_rd = 1'b1;
          state_d       = S_SRCH_CMP;
        end else begin
          cmd_o.idx_rd = 1'b1;
          state_d      = S_REM;
        end
      end
      S_SRCH_CMP: begin
        cmd_o.srch_cmp = 1'b1;
        state_d        = S_SRCH_CHK;
      end
      S_REM: begin
        cmd_o.rem_load = 1'b1;
        state_d        = S_WX0;
      end
      S_WX0: begin
        cmd_o.walk_lo = 1'b1;
        state_d       = S_WX1;
      end
      S_WX1: begin
        cmd_o.walk_hi = 1'b1;
        state_d       = S_WX2;
      end
      S_WX2: begin
        cmd_o.walk_pt = 1'b1;
        state_d       = S_WY0;
      end
      S_WY0: begin
        cmd_o.walk_sel_y = 1'b1;
        cmd_o.walk_lo    = 1'b1;
        state_d          = S_WY1;
      end
      S_WY1: begin
        cmd_o.walk_sel_y = 1'b1;
        cmd_o.walk_hi    = 1'b1;
        state_d          = S_WY2;
      end
      S_WY2: begin
        cmd_o.walk_sel_y = 1'b1;
        cmd_o.walk_pt    = 1'b1;
        state_d          = S_FLAGS;
      end
      S_FLAGS: begin
        cmd_o.flags = 1'b1;
        state_d     = S_FINISH;
      end
      S_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

// ===== rtl/core/polyline_arc_length_point.sv =====
// Polyline by arc length: a table of up to 256 vertices with per-segment length,
// unit direction and cumulative length, queried by distance along the path. One
// request is handled at a time; each yields one result, held in an output register
// so the next request is taken while the result waits. An append runs the 33-step
// square root and then two 49-step divisions on one shared divider; a query runs a
// binary search on the cumulative-length memory and then the walk on the shared
// multiplier. The user must write small_threshold only when idle; the block itself
// does not enforce it.
module polyline_arc_length_point (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  pal_pkg::req_t             in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output pal_pkg::rsp_t             out_rsp_o,
  input  logic                      cfg_we_i,
  input  logic [pal_pkg::THR_W-1:0] cfg_wdata_i
);
  import pal_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  pal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // tables and arithmetic
  pal_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
